// ===== hdl/eap_pkg.sv =====
// eap_pkg: shared types, codes and the control store for the eased animation progress block
// used by eap_sequencer, eap_datapath and eased_animation_progress_top
`default_nettype none

package eap_pkg;

   // input word
   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        now_ms;
      logic signed [31:0] elapsed_ms;
   } req_type;

   // result word
   typedef struct packed {
      logic        value_valid;
      logic [16:0] eased_value;
      logic        still_running;
      logic        done_event;
   } rsp_type;

   localparam int DurationBits = 16;
   localparam int ModeBits     = 3;
   localparam int CsrDataBits  = 16;
   localparam int CsrIndexBits = 1;
   localparam int ValueBits    = 17;

   localparam logic [CsrIndexBits-1:0] CSR_DURATION = 1'd0;
   localparam logic [CsrIndexBits-1:0] CSR_EASING   = 1'd1;

   localparam logic [1:0] CMD_TICK_TIME    = 2'd0;
   localparam logic [1:0] CMD_TICK_ELAPSED = 2'd1;
   localparam logic [1:0] CMD_FINISH       = 2'd2;
   localparam logic [1:0] CMD_NONE         = 2'd3;

   localparam logic [ModeBits-1:0] MODE_LINEAR      = 3'd0;
   localparam logic [ModeBits-1:0] MODE_IN_QUAD     = 3'd1;
   localparam logic [ModeBits-1:0] MODE_OUT_QUAD    = 3'd2;
   localparam logic [ModeBits-1:0] MODE_INOUT_QUAD  = 3'd3;
   localparam logic [ModeBits-1:0] MODE_IN_CUBIC    = 3'd4;
   localparam logic [ModeBits-1:0] MODE_OUT_CUBIC   = 3'd5;
   localparam logic [ModeBits-1:0] MODE_INOUT_CUBIC = 3'd6;
   localparam logic [ModeBits-1:0] MODE_SPARE       = 3'd7;

   // datapath operations
   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_DIVSTEP = 3'd2;
   localparam logic [2:0] OP_SETX    = 3'd3;
   localparam logic [2:0] OP_SQUARE  = 3'd4;
   localparam logic [2:0] OP_CUBE    = 3'd5;
   localparam logic [2:0] OP_SHAPE   = 3'd6;
   localparam logic [2:0] OP_EMIT    = 3'd7;

   // jump conditions
   localparam logic [2:0] COND_NONE    = 3'd0;
   localparam logic [2:0] COND_SPECIAL = 3'd1;
   localparam logic [2:0] COND_LAST    = 3'd2;
   localparam logic [2:0] COND_LOOP    = 3'd3;
   localparam logic [2:0] COND_LINEAR  = 3'd4;
   localparam logic [2:0] COND_QUAD    = 3'd5;

   localparam int PcBits = 3;

   // program step addresses
   localparam logic [PcBits-1:0] PC_LOAD  = 3'd0;
   localparam logic [PcBits-1:0] PC_CHECK = 3'd1;
   localparam logic [PcBits-1:0] PC_DIV   = 3'd2;
   localparam logic [PcBits-1:0] PC_SETX  = 3'd3;
   localparam logic [PcBits-1:0] PC_SQ    = 3'd4;
   localparam logic [PcBits-1:0] PC_CUBE  = 3'd5;
   localparam logic [PcBits-1:0] PC_SHAPE = 3'd6;
   localparam logic [PcBits-1:0] PC_EMIT  = 3'd7;

   typedef struct packed {
      logic [2:0]        op;
      logic [2:0]        cond;
      logic [PcBits-1:0] target;
   } ucode_type;

   // issued step, sequencer to datapath
   typedef struct packed {
      logic       en;
      logic [2:0] op;
   } ctrl_type;

   // condition flags, datapath to sequencer
   typedef struct packed {
      logic special;
      logic last;
      logic loop;
      logic linear;
      logic quad;
   } flags_type;

   function automatic ucode_type eap_rom(input logic [PcBits-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_NONE, target: PC_LOAD};
      case (pc)
         PC_LOAD:  w = '{op: OP_LOAD,    cond: COND_SPECIAL, target: PC_EMIT};
         PC_CHECK: w = '{op: OP_NOP,     cond: COND_LAST,    target: PC_SETX};
         PC_DIV:   w = '{op: OP_DIVSTEP, cond: COND_LOOP,    target: PC_DIV};
         PC_SETX:  w = '{op: OP_SETX,    cond: COND_LINEAR,  target: PC_SHAPE};
         PC_SQ:    w = '{op: OP_SQUARE,  cond: COND_QUAD,    target: PC_SHAPE};
         PC_CUBE:  w = '{op: OP_CUBE,    cond: COND_NONE,    target: PC_LOAD};
         PC_SHAPE: w = '{op: OP_SHAPE,   cond: COND_NONE,    target: PC_LOAD};
         PC_EMIT:  w = '{op: OP_EMIT,    cond: COND_NONE,    target: PC_LOAD};
         default:  w = '{op: OP_NOP,     cond: COND_NONE,    target: PC_LOAD};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/eap_sequencer.sv =====
// eap_sequencer: step counter, control store lookup and conditional jumps
// depends on eap_pkg
`default_nettype none

module eap_sequencer
   import eap_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire logic      out_free,
   input  wire flags_type flags,
   output ctrl_type       ctrl,
   output logic           busy
);

   logic              busy_ff, busy_in;
   logic [PcBits-1:0] pc_ff, pc_in;
   ucode_type         word;
   logic              take;
   logic              go;

   assign word = eap_rom(pc_ff);
   assign go   = busy_ff && ((word.op != OP_EMIT) || out_free);

   always_comb begin
      case (word.cond)
         COND_NONE:    take = 1'b0;
         COND_SPECIAL: take = flags.special;
         COND_LAST:    take = flags.last;
         COND_LOOP:    take = flags.loop;
         COND_LINEAR:  take = flags.linear;
         COND_QUAD:    take = flags.quad;
         default:      take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = PC_LOAD;
         end
      end else if (go) begin
         if (word.op == OP_EMIT) begin
            busy_in = 1'b0;
            pc_in   = PC_LOAD;
         end else if (take) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_LOAD;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctrl.en = go;
   assign ctrl.op = word.op;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

// ===== hdl/eap_datapath.sv =====
// eap_datapath: animation state, restoring divider, shared multiplier and easing shaping
// depends on eap_pkg; driven step by step by eap_sequencer
`default_nettype none

module eap_datapath
   import eap_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    capture,
   input  wire req_type                 item,
   input  wire logic [DurationBits-1:0] duration_ms,
   input  wire logic [ModeBits-1:0]     easing_mode,
   input  wire ctrl_type                ctrl,
   output flags_type                    flags,
   output rsp_type                      result
);

   localparam int W        = FRACTION_BITS + 1;
   localparam int CW       = $clog2(FRACTION_BITS + 1);
   localparam int PadBits  = 32 - W;
   localparam logic [W-1:0]   One   = W'(1) << FRACTION_BITS;
   localparam logic [W+1:0]   OneX  = (W + 2)'(1) << FRACTION_BITS;

   req_type          item_ff;
   logic             started_ff, started_in;
   logic             finished_ff, finished_in;
   logic [31:0]      start_time_ff, start_time_in;
   logic             last_ff, last_in;
   logic [15:0]      rem_ff, rem_in;
   logic [W-1:0]     t_ff, t_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [W-1:0]     x_ff, x_in;
   logic             half_ff, half_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic             res_valid_ff, res_valid_in;
   logic [W-1:0]     res_value_ff, res_value_in;
   logic             res_run_ff, res_run_in;
   logic             res_done_ff, res_done_in;

   logic [15:0]      dur;
   logic [31:0]      diff;
   logic [31:0]      el_raw;
   logic [30:0]      el;
   logic             reach;
   logic [16:0]      rem2;
   logic             qbit;
   logic [W-1:0]     inv;
   logic [2*W-1:0]   prod;
   logic [W+1:0]     scaled;
   logic [31:0]      value_ext;
   logic             m_linear, m_in, m_out, m_inout, m_quad, m_iq;

   assign dur = (duration_ms == '0) ? 16'd1 : duration_ms;

   // mode classes
   assign m_linear = (easing_mode == MODE_LINEAR) || (easing_mode == MODE_SPARE);
   assign m_in     = (easing_mode == MODE_IN_QUAD) || (easing_mode == MODE_IN_CUBIC);
   assign m_out    = (easing_mode == MODE_OUT_QUAD) || (easing_mode == MODE_OUT_CUBIC);
   assign m_inout  = (easing_mode == MODE_INOUT_QUAD) || (easing_mode == MODE_INOUT_CUBIC);
   assign m_iq     = (easing_mode == MODE_INOUT_QUAD);
   assign m_quad   = (easing_mode == MODE_IN_QUAD) || (easing_mode == MODE_OUT_QUAD) || m_iq;

   // elapsed time for a tick, clamped at zero
   assign diff   = item_ff.now_ms - (started_ff ? start_time_ff : item_ff.now_ms);
   assign el_raw = (item_ff.command == CMD_TICK_TIME) ? diff : 32'(item_ff.elapsed_ms);
   assign el     = el_raw[31] ? 31'd0 : el_raw[30:0];
   assign reach  = (|el[30:16]) || (el[15:0] >= dur);

   // one restoring divide step
   assign rem2 = {rem_ff, 1'b0};
   assign qbit = (rem2 >= {1'b0, dur});

   assign inv  = One - t_ff;
   assign prod = x_ff * ((ctrl.op == OP_SQUARE) ? x_ff : acc_ff);

   assign scaled = m_iq ? {1'b0, acc_ff, 1'b0} : {acc_ff, 2'b00};

   always_comb begin
      started_in    = started_ff;
      finished_in   = finished_ff;
      start_time_in = start_time_ff;
      last_in       = last_ff;
      rem_in        = rem_ff;
      t_in          = t_ff;
      count_in      = count_ff;
      x_in          = x_ff;
      half_in       = half_ff;
      acc_in        = acc_ff;
      res_valid_in  = res_valid_ff;
      res_value_in  = res_value_ff;
      res_run_in    = res_run_ff;
      res_done_in   = res_done_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_LOAD: begin
               res_value_in = '0;
               if (finished_ff) begin
                  res_valid_in = 1'b0;
                  res_run_in   = 1'b0;
                  res_done_in  = 1'b0;
               end else if (item_ff.command == CMD_NONE) begin
                  res_valid_in = 1'b0;
                  res_run_in   = 1'b1;
                  res_done_in  = 1'b0;
               end else if (item_ff.command == CMD_FINISH) begin
                  started_in   = 1'b1;
                  finished_in  = 1'b1;
                  res_valid_in = 1'b1;
                  res_value_in = One;
                  res_run_in   = 1'b0;
                  res_done_in  = 1'b1;
               end else begin
                  if (!started_ff) begin
                     started_in    = 1'b1;
                     start_time_in = (item_ff.command == CMD_TICK_TIME) ?
                                     item_ff.now_ms : 32'd0;
                  end
                  if (reach) begin
                     finished_in = 1'b1;
                  end
                  last_in      = reach;
                  t_in         = reach ? One : '0;
                  rem_in       = el[15:0];
                  count_in     = CW'(FRACTION_BITS);
                  res_valid_in = 1'b1;
                  res_run_in   = !reach;
                  res_done_in  = reach;
               end
            end
            OP_DIVSTEP: begin
               rem_in   = qbit ? 16'(rem2 - {1'b0, dur}) : rem2[15:0];
               t_in     = {t_ff[W-2:0], qbit};
               count_in = count_ff - 1'b1;
            end
            OP_SETX: begin
               half_in = (t_ff[W-1:W-2] == 2'b00);
               if (m_in || (m_inout && (t_ff[W-1:W-2] == 2'b00))) begin
                  x_in = t_ff;
               end else begin
                  x_in = inv;
               end
            end
            OP_SQUARE, OP_CUBE: begin
               acc_in = prod[FRACTION_BITS+W-1:FRACTION_BITS];
            end
            OP_SHAPE: begin
               if (m_linear) begin
                  res_value_in = t_ff;
               end else if (m_in) begin
                  res_value_in = acc_ff;
               end else if (m_out) begin
                  res_value_in = One - acc_ff;
               end else if (half_ff) begin
                  res_value_in = scaled[W-1:0];
               end else begin
                  res_value_in = W'(OneX - scaled);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         finished_ff   <= 1'b0;
         start_time_ff <= '0;
      end else begin
         started_ff    <= started_in;
         finished_ff   <= finished_in;
         start_time_ff <= start_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         item_ff <= item;
      end
      last_ff      <= last_in;
      rem_ff       <= rem_in;
      t_ff         <= t_in;
      count_ff     <= count_in;
      x_ff         <= x_in;
      half_ff      <= half_in;
      acc_ff       <= acc_in;
      res_valid_ff <= res_valid_in;
      res_value_ff <= res_value_in;
      res_run_ff   <= res_run_in;
      res_done_ff  <= res_done_in;
   end

   assign flags.special = finished_ff || (item_ff.command == CMD_FINISH) ||
                          (item_ff.command == CMD_NONE);
   assign flags.last    = last_ff;
   assign flags.loop    = (count_ff != CW'(1));
   assign flags.linear  = m_linear;
   assign flags.quad    = m_quad;

   assign value_ext            = {{PadBits{1'b0}}, res_value_ff};
   assign result.value_valid   = res_valid_ff;
   assign result.eased_value   = value_ext[ValueBits-1:0];
   assign result.still_running = res_run_ff;
   assign result.done_event    = res_done_ff;

endmodule

`default_nettype wire

// ===== hdl/eased_animation_progress_top.sv =====
// eased_animation_progress_top: top level of the eased animation progress block
// depends on eap_pkg, eap_sequencer and eap_datapath
`default_nettype none

// One-shot animation progress with easing. Each req word carries a command:
// tick with the current time (the first one latches the start time), tick
// with an elapsed time, or finish now. Elapsed time is clamped at zero and
// divided by duration_ms into progress t with FRACTION_BITS fraction bits,
// saturating at one; one of seven easing curves is applied and the rsp word
// reports the eased value, whether the animation runs on, and a done flag on
// the completing word. After completion every word reports not-running with
// no value until reset. Each accepted word runs a microcoded program: finish
// and no-op commands go from load to emit; ticks run load, check, the divide
// steps (skipped on the final tick), set-x, square and cube as the curve
// needs, shape and emit; the restoring divider yields one quotient bit per
// cycle. A new word is taken once the previous result sits in the output
// register, even while rsp is stalled. Configuration is to be written through
// csr_write/csr_index/csr_data while the block is idle; nothing enforces it.
module eased_animation_progress_top
   import eap_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input channel
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_type                 req_word,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_type                      rsp_word,
   // configuration writes
   input  wire logic                    csr_write,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_data
);

   logic [DurationBits-1:0] duration_ff, duration_in;
   logic [ModeBits-1:0]     mode_ff, mode_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_word_ff;

   logic      busy;
   logic      req_accept;
   logic      out_free;
   logic      emit;
   ctrl_type  ctrl;
   flags_type flags;
   rsp_type   result;

   // configuration registers
   always_comb begin
      duration_in = duration_ff;
      mode_in     = mode_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DURATION: duration_in = csr_data;
            CSR_EASING:   mode_in     = csr_data[ModeBits-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= 16'd1;
         mode_ff     <= MODE_LINEAR;
      end else begin
         duration_ff <= duration_in;
         mode_ff     <= mode_in;
      end
   end

   // one word in flight; the output register frees the input side early
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = ctrl.en && (ctrl.op == OP_EMIT);

   eap_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .out_free (out_free),
      .flags    (flags),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   eap_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .capture     (req_accept),
      .item        (req_word),
      .duration_ms (duration_ff),
      .easing_mode (mode_ff),
      .ctrl        (ctrl),
      .flags       (flags),
      .result      (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire
